FILE: sv/crcfc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the frame checker.
// No dependencies; imported by crcfc_frame_state and crc32_frame_checker.
package crcfc_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CRC_W      = 32;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned FILL_W     = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned OUT_USER_W = 2;

    localparam logic [CRC_W-1:0]  CRC_POLY     = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0]  CRC_XOR_OUT  = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0]  CRC_START_RST = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] RETRY_LIMIT_RST = 4'd2;
    localparam logic [FILL_W-1:0] FILL_FULL    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CRC_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 2'd1;

    typedef enum logic [1:0] {
        VERDICT_OK      = 2'd0,
        VERDICT_BAD     = 2'd1,
        VERDICT_GIVE_UP = 2'd2,
        VERDICT_SHORT   = 2'd3
    } t_verdict;

    typedef struct packed {
        t_verdict             verdict;
        logic [CRC_W-1:0]     computed_crc;
        logic [CRC_W-1:0]     received_crc;
        logic [COUNT_W-1:0]   retries_used;
    } t_result;

    // Direct-form shift register fed with the byte LSB first (reflected input).
    function automatic logic [CRC_W-1:0] crc_feed_byte(
        input logic [CRC_W-1:0]  acc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        logic             top;
        c = acc;
        for (int k = 0; k < BYTE_W; k++) begin
            top = c[CRC_W-1] ^ data[k];
            c   = {c[CRC_W-2:0], 1'b0};
            if (top) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [CRC_W-1:0] reverse32(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int k = 0; k < CRC_W; k++) begin
            r[k] = v[CRC_W-1-k];
        end
        return r;
    endfunction

endpackage

FILE: sv/crcfc_frame_state.sv
// Per-frame state of the checker: CRC accumulator, trailer window, fill, bad count.
// Depends on crcfc_pkg; instantiated by crc32_frame_checker.
module crcfc_frame_state (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [crcfc_pkg::BYTE_W-1:0] i_byte,
    input  logic                         i_last,
    input  logic [crcfc_pkg::CRC_W-1:0]  i_start_value,
    input  logic [crcfc_pkg::COUNT_W-1:0] i_retry_limit,
    output crcfc_pkg::t_result           o_result
);
    import crcfc_pkg::*;

    logic [CRC_W-1:0]   r_acc,    n_acc;
    logic [CRC_W-1:0]   r_window, n_window;
    logic [FILL_W-1:0]  r_fill,   n_fill;
    logic [COUNT_W-1:0] r_bad,    n_bad;

    logic [CRC_W-1:0]   fed_acc;
    logic [CRC_W-1:0]   shifted;
    logic [FILL_W-1:0]  fill_inc;
    logic [CRC_W-1:0]   final_crc;
    logic [COUNT_W:0]   bad_next;

    always_comb begin
        // Fold the byte leaving the window into the CRC once the window is full.
        fed_acc   = (r_fill >= FILL_FULL) ? crc_feed_byte(r_acc, r_window[BYTE_W-1:0]) : r_acc;
        shifted   = {i_byte, r_window[CRC_W-1:BYTE_W]};
        fill_inc  = (r_fill < FILL_FULL) ? r_fill + 3'd1 : r_fill;
        final_crc = reverse32(fed_acc) ^ CRC_XOR_OUT;
        bad_next  = {1'b0, r_bad} + 5'd1;

        o_result.retries_used = r_bad;
        o_result.verdict      = VERDICT_SHORT;
        o_result.computed_crc = '0;
        o_result.received_crc = '0;
        n_bad                 = r_bad;

        if (fill_inc >= FILL_FULL) begin
            o_result.computed_crc = final_crc;
            o_result.received_crc = shifted;
            if (final_crc == shifted) begin
                o_result.verdict = VERDICT_OK;
                n_bad            = '0;
            end else if (bad_next >= {1'b0, i_retry_limit}) begin
                o_result.verdict = VERDICT_GIVE_UP;
                n_bad            = '0;
            end else begin
                o_result.verdict = VERDICT_BAD;
                n_bad            = bad_next[COUNT_W-1:0];
            end
        end

        if (i_last) begin
            n_acc    = i_start_value;
            n_window = '0;
            n_fill   = '0;
        end else begin
            n_acc    = fed_acc;
            n_window = shifted;
            n_fill   = fill_inc;
            n_bad    = r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= CRC_START_RST;
            r_window <= '0;
            r_fill   <= '0;
            r_bad    <= '0;
        end else if (i_step) begin
            r_acc    <= n_acc;
            r_window <= n_window;
            r_fill   <= n_fill;
            r_bad    <= n_bad;
        end
    end

endmodule

FILE: sv/crc32_frame_checker.sv
// CRC-32 frame checker: one received byte per word in, one verdict word per frame out.
// The verdict is registered after the last byte passes the input register, in the
// result register. Throughput: one byte per cycle unless a last byte waits on a held
// result register; limited by the byte-wide CRC update and trailer compare between them.
// Synchronous active-low reset: CRC start 0xFFFFFFFF, retry limit 2, window empty.
module crc32_frame_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [crcfc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [crcfc_pkg::CRC_W-1:0]       i_cfg_data,
    // byte stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [crcfc_pkg::BYTE_W-1:0]      s_axis_tdata,   // [7:0] data_byte
    input  logic                              s_axis_tlast,   // last_byte
    // verdict stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [crcfc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [31:0] computed_crc,
                                                              // [63:32] received_crc,
                                                              // [67:64] retries_used,
                                                              // [71:68] zero
    output logic [crcfc_pkg::OUT_USER_W-1:0]  m_axis_tuser    // [1:0] verdict
);
    import crcfc_pkg::*;

    // Configuration registers; the user must write them only while the block is idle (not enforced by the block).
    logic [CRC_W-1:0]   r_start_value;
    logic [COUNT_W-1:0] r_retry_limit;

    // Input register stage.
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_in_last;

    // Result register stage.
    logic               r_out_valid;
    t_result            r_out;

    t_result            result;
    logic               out_free;
    logic               step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_value <= CRC_START_RST;
            r_retry_limit <= RETRY_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CRC_START:   r_start_value <= i_cfg_data;
                REG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[COUNT_W-1:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // A byte that ends no frame never needs the result register, so advance it
    // freely; a last byte waits until the result register is empty or draining.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    crcfc_frame_state u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .i_start_value (r_start_value),
        .i_retry_limit (r_retry_limit),
        .o_result      (result)
    );

    // Hold the verdict until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.retries_used, r_out.received_crc,
                            r_out.computed_crc};
    assign m_axis_tuser  = r_out.verdict;

endmodule
